### hw/rtl/tssl_pkg.sv
package tssl_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	// fixed decode constants
	localparam int SCAN_FIRST = 4;
	localparam int SCAN_END   = 64;
	localparam int RUN_LEN    = 5;
	localparam int BIT_MARGIN = 2;
	localparam int SLOT_FIELD = 32;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_START   = 2'd1,
		OP_FINISH  = 2'd2,
		OP_PROCESS = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_PULSE = 3'd1,
		PH_SYNC  = 3'd2,
		PH_READ  = 3'd3,
		PH_END   = 3'd4,
		PH_NOACT = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CFG_PULSE    = 3'd0,
		CFG_PRESYNC  = 3'd1,
		CFG_SYNC     = 3'd2,
		CFG_OFFSET   = 3'd3,
		CFG_USEDLAST = 3'd4,
		CFG_UPPER    = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_SLOT,
		ST_BITS,
		ST_WRITE,
		ST_STATUS
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       line_level;
	} in_item_t;

	typedef struct packed {
		logic       report_kind;
		logic [4:0] slot;
		logic [2:0] slot_flags;
		logic       flags_changed;
		logic [5:0] before_count;
		logic [5:0] online_count;
		logic [5:0] gap_count;
		logic [5:0] after_count;
		logic [2:0] phase;
		logic       start_waiting;
		logic       init_drive;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic scan_init;
		logic scan_run;
		logic dec_begin;
		logic no_active;
		logic bits_init;
		logic bits_run;
		logic slot_write;
		logic status_load;
	} dp_cmd_t;

	typedef struct packed {
		logic decode_req;
		logic out_free;
		logic scan_done;
		logic found;
		logic slot_used;
		logic bits_done;
		logic slot_emit;
		logic slot_final;
		logic emitted_any;
	} dp_status_t;

endpackage

### hw/rtl/tssl_ctrl.sv
module tssl_ctrl import tssl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.decode_req) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.found ? ST_SLOT : ST_STATUS;
			end
			ST_SLOT: begin
				state_d = sts.slot_used ? ST_BITS : ST_WRITE;
			end
			ST_BITS: begin
				if (sts.bits_done) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!sts.slot_emit || sts.out_free) begin
					if (!sts.slot_final) state_d = ST_SLOT;
					else if (sts.emitted_any || sts.slot_emit) state_d = ST_IDLE;
					else state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.step      = accept && !sts.decode_req;
				cmd.scan_init = accept && sts.decode_req;
			end
			ST_SCAN:  cmd.scan_run = 1'b1;
			ST_CHECK: begin
				cmd.dec_begin = sts.found;
				cmd.no_active = !sts.found;
			end
			ST_SLOT:  cmd.bits_init = sts.slot_used;
			ST_BITS:  cmd.bits_run = 1'b1;
			ST_WRITE: cmd.slot_write = !sts.slot_emit || sts.out_free;
			ST_STATUS: cmd.status_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/tssl_dp.sv
module tssl_dp import tssl_pkg::*; #(
	parameter int NUM_SLOTS     = 32,
	parameter int CAPTURE_TICKS = 1024,
	parameter int SLOT_TICKS    = 24,
	parameter int PAUSE_TICKS   = 4,
	parameter int BIT_TICKS     = 8,
	parameter int AREA_TICKS    = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  in_item_t          in_data,
	output out_item_t         out_data,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_valid,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  dp_cmd_t           cmd,
	output dp_status_t        sts
);

	localparam int AW   = $clog2(CAPTURE_TICKS);
	localparam int PW   = $clog2(CAPTURE_TICKS + 1);
	localparam int SLW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int BW   = $clog2(SLOT_TICKS * NUM_SLOTS + 128 + 2 * AREA_TICKS) + 1;
	localparam int WIN  = 2 * PAUSE_TICKS + 2 * BIT_TICKS;
	localparam int EMIT_N = (NUM_SLOTS < SLOT_FIELD) ? NUM_SLOTS : SLOT_FIELD;
	localparam int SCAN_N = SCAN_END - SCAN_FIRST;

	// configuration
	logic [15:0] pulse_ticks_q, sync_ticks_q;
	logic        presync_q;
	logic [5:0]  offset_q, upper_q;
	logic [4:0]  used_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q <= 16'd100;
			presync_q     <= 1'b0;
			sync_ticks_q  <= 16'd10;
			offset_q      <= 6'd4;
			used_last_q   <= 5'd31;
			upper_q       <= 6'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PULSE:    pulse_ticks_q <= cfg_data;
				CFG_PRESYNC:  presync_q     <= cfg_data[0];
				CFG_SYNC:     sync_ticks_q  <= cfg_data;
				CFG_OFFSET:   offset_q      <= cfg_data[5:0];
				CFG_USEDLAST: used_last_q   <= cfg_data[4:0];
				CFG_UPPER:    upper_q       <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// poll state
	phase_t       phase_q, phase_d;
	logic [15:0]  cd_q, cd_d;
	logic [PW-1:0] pos_q, pos_d;
	logic         pending_q, pending_d, drive_q, drive_d;
	logic         busy, want, mem_we;

	assign busy = (phase_q == PH_PULSE) || (phase_q == PH_SYNC) ||
		(phase_q == PH_READ) || (phase_q == PH_END);
	assign want = pending_q || (in_data.opcode == OP_START && !busy);

	always_comb begin
		phase_d   = phase_q;
		cd_d      = cd_q;
		pos_d     = pos_q;
		pending_d = pending_q;
		drive_d   = drive_q;
		mem_we    = 1'b0;
		unique case (in_data.opcode)
			OP_TICK: begin
				priority if (phase_q == PH_PULSE) begin
					if (cd_q <= 16'd1) begin
						drive_d = 1'b0;
						if (presync_q) begin
							cd_d    = sync_ticks_q;
							phase_d = PH_SYNC;
						end else begin
							pos_d   = '0;
							phase_d = PH_READ;
						end
					end else begin
						cd_d = cd_q - 16'd1;
					end
				end else if (phase_q == PH_SYNC) begin
					if (cd_q <= 16'd1) begin
						pos_d   = '0;
						phase_d = PH_READ;
					end else begin
						cd_d = cd_q - 16'd1;
					end
				end else if (phase_q == PH_READ) begin
					mem_we = 1'b1;
					pos_d  = pos_q + PW'(1);
					if (pos_d >= PW'(CAPTURE_TICKS)) phase_d = PH_END;
				end else begin
				end
			end
			OP_FINISH: begin
				pending_d = 1'b0;
				drive_d   = 1'b0;
				phase_d   = PH_WAIT;
			end
			default: begin
				if (want && !busy) begin
					pending_d = 1'b0;
					drive_d   = 1'b1;
					cd_d      = pulse_ticks_q;
					phase_d   = PH_PULSE;
				end else begin
					pending_d = want;
				end
			end
		endcase
	end

	assign sts.decode_req = (in_data.opcode == OP_START || in_data.opcode == OP_PROCESS) &&
		!(want && !busy) && phase_q == PH_END;

	// capture memory
	logic          mem [CAPTURE_TICKS];
	logic [AW-1:0] rd_addr;
	logic          rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.step && mem_we) mem[pos_q[AW-1:0]] <= ~in_data.line_level;
		rd_s1 <= mem[rd_addr];
	end

	// scan for the start run
	logic [6:0] k_q;
	logic [5:0] pos_s1, run_start_q, rs_eff;
	logic [2:0] run_q;
	logic       scan_v_s1, found_q;
	logic [6:0] start_idx_q;

	assign sts.scan_done = (k_q == 7'(SCAN_N));
	assign sts.found     = found_q;
	assign rs_eff        = (run_q == 3'd0) ? pos_s1 : run_start_q;

	// slot walk
	logic [SLW-1:0] slot_q;
	logic [BW-1:0]  base_q, slot_addr;
	logic [6:0]     bit_q, bit_s1;
	logic           bits_v_s1, inr_s1, inrange, smp, after_run_q, any_q;
	logic [5:0]     c0_q, c1_q, c2_q, c3_q;
	logic [6:0]     len;
	logic [2:0]     flags_c, flags_w;
	logic [7:0]     slot8, nxt8, upmax;
	logic           used, emit, later;
	logic [2:0]     fstore [NUM_SLOTS];

	assign slot_addr = base_q + BW'(bit_q);
	assign inrange   = (bit_q < 7'(AREA_TICKS)) && (slot_addr < BW'(CAPTURE_TICKS));
	assign smp       = rd_s1 && inr_s1;

	always_comb begin
		if (cmd.scan_run) rd_addr = AW'(k_q) + AW'(SCAN_FIRST);
		else rd_addr = slot_addr[AW-1:0];
	end

	assign slot8 = 8'(slot_q);
	assign nxt8  = slot8 + 8'd1;
	assign used  = (slot8 <= 8'(used_last_q)) || (slot8 >= 8'(upper_q));
	assign emit  = used && (slot8 < 8'(SLOT_FIELD));
	assign upmax = (nxt8 > 8'(upper_q)) ? nxt8 : 8'(upper_q);
	assign later = ((nxt8 <= 8'(used_last_q)) && (nxt8 < 8'(EMIT_N))) ||
		(upmax < 8'(EMIT_N));

	always_comb begin
		flags_c = 3'd0;
		len = 7'(c1_q) + 7'(c2_q);
		if (c0_q == 6'd0) begin
			len = len + 7'(c3_q);
			if (c3_q >= 6'(PAUSE_TICKS)) flags_c[0] = 1'b1;
		end else if (c3_q == 6'd0) begin
			len = len + 7'(c0_q);
			if (c0_q >= 6'(PAUSE_TICKS)) flags_c[0] = 1'b1;
		end
		if (len >= 7'(BIT_TICKS - BIT_MARGIN)) flags_c[1] = 1'b1;
		if (len >= 7'((BIT_TICKS - BIT_MARGIN) * 2)) flags_c[2] = 1'b1;
	end

	assign flags_w = used ? flags_c : 3'd0;

	assign sts.slot_used   = used;
	assign sts.slot_emit   = emit;
	assign sts.slot_final  = (slot8 == 8'(NUM_SLOTS - 1));
	assign sts.bits_done   = (bit_q == 7'(WIN));
	assign sts.emitted_any = any_q;

	// output register
	logic      out_v_q;
	logic      out_ld;
	out_item_t out_nx;

	assign out_valid    = out_v_q;
	assign sts.out_free = !out_v_q || out_ready;
	assign out_ld       = cmd.step || cmd.status_load || (cmd.slot_write && emit);

	always_comb begin
		out_nx = '0;
		if (cmd.step) begin
			out_nx.phase         = phase_d;
			out_nx.start_waiting = pending_d;
			out_nx.init_drive    = drive_d;
			out_nx.last          = 1'b1;
		end else if (cmd.status_load) begin
			out_nx.phase         = phase_q;
			out_nx.start_waiting = pending_q;
			out_nx.init_drive    = drive_q;
			out_nx.last          = 1'b1;
		end else begin
			out_nx.report_kind   = 1'b1;
			out_nx.slot          = 5'(slot_q);
			out_nx.slot_flags    = flags_c;
			out_nx.flags_changed = (flags_c != fstore[slot_q]);
			out_nx.before_count  = c0_q;
			out_nx.online_count  = c1_q;
			out_nx.gap_count     = c2_q;
			out_nx.after_count   = c3_q;
			out_nx.phase         = phase_q;
			out_nx.start_waiting = pending_q;
			out_nx.init_drive    = drive_q;
			out_nx.last          = !later;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			cd_q        <= '0;
			pos_q       <= '0;
			pending_q   <= 1'b0;
			drive_q     <= 1'b0;
			out_v_q     <= 1'b0;
			k_q         <= '0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			run_q       <= '0;
			bits_v_s1   <= 1'b0;
			bit_q       <= '0;
			slot_q      <= '0;
			any_q       <= 1'b0;
			after_run_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) fstore[i] <= 3'd0;
		end else begin
			out_v_q <= out_ld || (out_v_q && !out_ready);

			if (cmd.step) begin
				phase_q   <= phase_d;
				cd_q      <= cd_d;
				pos_q     <= pos_d;
				pending_q <= pending_d;
				drive_q   <= drive_d;
			end

			if (cmd.scan_init) begin
				k_q       <= '0;
				scan_v_s1 <= 1'b0;
				found_q   <= 1'b0;
				run_q     <= '0;
			end
			if (cmd.scan_run) begin
				scan_v_s1 <= (k_q < 7'(SCAN_N));
				if (k_q < 7'(SCAN_N)) k_q <= k_q + 7'd1;
				if (scan_v_s1 && !found_q) begin
					if (rd_s1) begin
						run_q <= run_q + 3'd1;
						if (run_q == 3'(RUN_LEN - 1)) found_q <= 1'b1;
					end else begin
						run_q <= '0;
					end
				end
			end

			if (cmd.dec_begin) begin
				phase_q <= PH_WAIT;
				slot_q  <= '0;
				any_q   <= 1'b0;
			end
			if (cmd.no_active) begin
				phase_q <= PH_NOACT;
				for (int i = 0; i < NUM_SLOTS; i++) fstore[i] <= 3'd0;
			end

			if (cmd.bits_init) begin
				bit_q       <= '0;
				bits_v_s1   <= 1'b0;
				after_run_q <= 1'b1;
			end
			if (cmd.bits_run) begin
				bits_v_s1 <= (bit_q < 7'(WIN));
				if (bit_q < 7'(WIN)) bit_q <= bit_q + 7'd1;
				if (bits_v_s1 && bit_s1 >= 7'(PAUSE_TICKS + 2 * BIT_TICKS)) begin
					if (!smp) after_run_q <= 1'b0;
				end
			end

			if (cmd.slot_write) begin
				fstore[slot_q] <= flags_w;
				if (emit) any_q <= 1'b1;
				slot_q <= slot_q + SLW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			pos_s1 <= 6'(k_q) + 6'(SCAN_FIRST);
			if (scan_v_s1 && !found_q && rd_s1) begin
				run_start_q <= rs_eff;
				if (run_q == 3'(RUN_LEN - 1)) start_idx_q <= 7'(rs_eff) + 7'(offset_q);
			end
		end
		if (cmd.dec_begin) base_q <= BW'(start_idx_q);
		if (cmd.slot_write) base_q <= base_q + BW'(SLOT_TICKS);
		if (cmd.bits_init) begin
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
		end
		if (cmd.bits_run) begin
			bit_s1 <= bit_q;
			inr_s1 <= inrange;
			if (bits_v_s1) begin
				if (bit_s1 < 7'(PAUSE_TICKS)) begin
					c0_q <= smp ? c0_q + 6'd1 : 6'd0;
				end else if (bit_s1 < 7'(PAUSE_TICKS + BIT_TICKS)) begin
					c1_q <= c1_q + 6'(smp);
				end else if (bit_s1 < 7'(PAUSE_TICKS + 2 * BIT_TICKS)) begin
					c2_q <= c2_q + 6'(smp);
				end else if (after_run_q && smp) begin
					c3_q <= c3_q + 6'd1;
				end
			end
		end

		if (out_ld) out_data <= out_nx;
	end

endmodule

### hw/rtl/time_slot_sensor_line_poller.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (in_item_t)
// out      output     out_valid / out_ready  out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// tick and finish words, and start and process words outside the end phase, each
// leave one status word in the output register; a word is taken in the
// same cycle the previous result is drained.
// a start or process word at the end phase walks the capture memory at one sample a
// cycle: first the search for the start run, then a sample window per used slot
// and none per unused slot, plus output stalls.
// reset is asynchronous; the capture memory is not cleared.
module time_slot_sensor_line_poller import tssl_pkg::*; #(
	parameter int NUM_SLOTS     = 32,
	parameter int CAPTURE_TICKS = 1024,
	parameter int SLOT_TICKS    = 24,
	parameter int PAUSE_TICKS   = 4,
	parameter int BIT_TICKS     = 8,
	parameter int AREA_TICKS    = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	tssl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tssl_dp #(
		.NUM_SLOTS     (NUM_SLOTS),
		.CAPTURE_TICKS (CAPTURE_TICKS),
		.SLOT_TICKS    (SLOT_TICKS),
		.PAUSE_TICKS   (PAUSE_TICKS),
		.BIT_TICKS     (BIT_TICKS),
		.AREA_TICKS    (AREA_TICKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
